>>> rtl/avcc_a2b_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package avcc_a2b_pkg;

  localparam int unsigned HdrLen       = 5;
  localparam logic [7:0]  VersionOne   = 8'd1;
  localparam logic [7:0]  SpsCountMask = 8'd31;
  localparam logic [7:0]  StartCode [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_SHORT_HDR   = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_TRAILING    = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    PH_HEADER    = 8'b0000_0001,
    PH_SPS_COUNT = 8'b0000_0010,
    PH_LEN_HI    = 8'b0000_0100,
    PH_LEN_LO    = 8'b0000_1000,
    PH_PAYLOAD   = 8'b0001_0000,
    PH_PPS_COUNT = 8'b0010_0000,
    PH_DONE      = 8'b0100_0000,
    PH_REJECT    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic [2:0] status;
    logic       run_last;
  } out_beat_t;

  // results caused by one input beat
  typedef struct packed {
    logic       start_code;
    logic       data;
    logic [7:0] data_byte;
    logic       is_end;
    logic [2:0] status;
  } burst_t;

endpackage

`default_nettype wire

>>> rtl/avcc_a2b_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module avcc_a2b_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  avcc_a2b_pkg::in_beat_t in_data,
  output avcc_a2b_pkg::burst_t   burst
);
  import avcc_a2b_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [7:0]  sets_r, sets_nxt;
  logic        pps_r, pps_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic [2:0]  err_r, err_nxt;

  function automatic phase_t enter_phase(input logic [7:0] sets, input logic pps);
    phase_t ph;
    if (sets != 8'd0) begin
      ph = PH_LEN_HI;
    end else if (!pps) begin
      ph = PH_PPS_COUNT;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

  always_comb begin
    logic [7:0] b;
    b          = in_data.in_byte;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    sets_nxt   = sets_r;
    pps_nxt    = pps_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    err_nxt    = err_r;
    burst      = '0;

    case (phase_r)
      PH_HEADER: begin
        if (hidx_r == 3'd0 && b != VersionOne) begin
          err_nxt   = ST_BAD_VERSION;
          phase_nxt = PH_REJECT;
        end else begin
          hidx_nxt = hidx_r + 3'd1;
          if (hidx_nxt >= 3'(HdrLen)) begin
            phase_nxt = PH_SPS_COUNT;
          end
        end
      end
      PH_SPS_COUNT: begin
        sets_nxt  = b & SpsCountMask;
        pps_nxt   = 1'b0;
        phase_nxt = enter_phase(sets_nxt, 1'b0);
      end
      PH_LEN_HI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        left_nxt         = {len_hi_r, b};
        burst.start_code = 1'b1;
        if (left_nxt == 16'd0) begin
          sets_nxt  = sets_r - 8'd1;
          phase_nxt = enter_phase(sets_nxt, pps_r);
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        burst.data      = 1'b1;
        burst.data_byte = b;
        left_nxt        = left_r - 16'd1;
        if (left_nxt == 16'd0) begin
          sets_nxt  = sets_r - 8'd1;
          phase_nxt = enter_phase(sets_nxt, pps_r);
        end
      end
      PH_PPS_COUNT: begin
        sets_nxt  = b;
        pps_nxt   = 1'b1;
        phase_nxt = enter_phase(b, 1'b1);
      end
      PH_DONE: begin
        if (err_r == ST_OK) begin
          err_nxt = ST_TRAILING;
        end
      end
      default: begin
        phase_nxt = PH_REJECT;
      end
    endcase

    if (in_data.in_last) begin
      burst.is_end = 1'b1;
      if (err_nxt != ST_OK) begin
        burst.status = err_nxt;
      end else if (phase_nxt == PH_HEADER || phase_nxt == PH_SPS_COUNT) begin
        burst.status = ST_SHORT_HDR;
      end else if (phase_nxt == PH_DONE) begin
        burst.status = ST_OK;
      end else begin
        burst.status = ST_TRUNCATED;
      end
      phase_nxt  = PH_HEADER;
      hidx_nxt   = 3'd0;
      sets_nxt   = 8'd0;
      pps_nxt    = 1'b0;
      len_hi_nxt = 8'd0;
      left_nxt   = 16'd0;
      err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hidx_r   <= 3'd0;
      sets_r   <= 8'd0;
      pps_r    <= 1'b0;
      len_hi_r <= 8'd0;
      left_r   <= 16'd0;
      err_r    <= ST_OK;
    end else if (take) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      sets_r   <= sets_nxt;
      pps_r    <= pps_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/avcc_config_to_annexb_unit.sv
// First result of an input beat is registered; it appears the cycle after it is accepted.
// Throughput: one input beat per cycle while each beat yields at most one result
// and out_ready is high; a beat that yields more results holds input until its last
// result is sent, so a set length (four start-code beats) stalls input.
// The output register holds up to five results of one beat and sends one per ready cycle.
// Reset (rst_n low at a clock edge) returns the parser to the header phase and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module avcc_config_to_annexb_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  avcc_a2b_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output avcc_a2b_pkg::out_beat_t out_data
);
  import avcc_a2b_pkg::*;

  burst_t     burst;
  logic       take;
  logic       last_beat;
  logic       body;
  logic [2:0] nbody_nxt;

  logic [2:0] n_r, n_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [2:0] nbody_r;
  logic       sc_r;
  logic [7:0] byte_r;
  logic [2:0] status_r;

  assign out_valid = (n_r != 3'd0);
  assign last_beat = (pos_r == n_r - 3'd1);
  assign in_ready  = !out_valid || (out_ready && last_beat);
  assign take      = in_valid && in_ready;

  avcc_a2b_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .burst   (burst)
  );

  always_comb begin
    if (burst.start_code) begin
      nbody_nxt = 3'd4;
    end else if (burst.data) begin
      nbody_nxt = 3'd1;
    end else begin
      nbody_nxt = 3'd0;
    end

    n_nxt   = n_r;
    pos_nxt = pos_r;
    if (take) begin
      n_nxt   = nbody_nxt + {2'b00, burst.is_end};
      pos_nxt = 3'd0;
    end else if (out_valid && out_ready) begin
      if (last_beat) begin
        n_nxt = 3'd0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= 3'd0;
      pos_r <= 3'd0;
    end else begin
      n_r   <= n_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      nbody_r  <= nbody_nxt;
      sc_r     <= burst.start_code;
      byte_r   <= burst.data_byte;
      status_r <= burst.status;
    end
  end

  assign body = (pos_r < nbody_r);

  always_comb begin
    out_data = '0;
    if (body) begin
      out_data.out_byte = sc_r ? StartCode[pos_r[1:0]] : byte_r;
    end else begin
      out_data.is_end = 1'b1;
      out_data.status = status_r;
    end
    out_data.run_last = last_beat;
  end

endmodule

`default_nettype wire

>>> rtl/avcc_a2b_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module avcc_a2b_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input avcc_a2b_pkg::out_beat_t out_data
);
  import avcc_a2b_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_end |-> out_data.run_last && out_data.out_byte == 8'd0)
    else $error("end beat malformed");

  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_end |-> out_data.status == ST_OK)
    else $error("status on data beat");

  // drop input while a multi-beat burst still drains
  a_no_take_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input taken mid burst");

endmodule

bind avcc_config_to_annexb_unit avcc_a2b_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
